/* rtl/ppd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polarization product detector package
// Shared widths, mode codes, channel structs and queue entry type.
// ----------------------------------------------------------------------------
package ppd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int VALUE_BITS  = 35;
   localparam int MODE_BITS   = 2;
   localparam int SLOT_BITS   = 2;
   localparam int NUM_VALUES  = 4;
   localparam int NUM_PRODS   = 8;
   // Operands carry one extra bit for the sums and differences of the circular mode.
   localparam int OP_BITS     = SAMPLE_BITS + 1;
   localparam int PROD_BITS   = 2 * OP_BITS;

   localparam logic [MODE_BITS-1:0] MODE_INTENSITY = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_LINEAR    = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_CIRCULAR  = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_STOKES    = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x_re;
      logic signed [SAMPLE_BITS-1:0] x_im;
      logic signed [SAMPLE_BITS-1:0] y_re;
      logic signed [SAMPLE_BITS-1:0] y_im;
   } ppd_req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] product_value;
      logic [SLOT_BITS-1:0]         product_slot;
      logic                         last_of_run;
   } ppd_rsp_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]                   mode;
      logic [NUM_VALUES-1:0][VALUE_BITS-1:0]  value;
   } ppd_entry_type;

   // Slot number of the final product of a run in the given mode.
   function automatic logic [SLOT_BITS-1:0] last_slot(input logic [MODE_BITS-1:0] mode);
      logic [SLOT_BITS-1:0] slot;
      unique case (mode)
         MODE_INTENSITY: slot = 2'd0;
         MODE_LINEAR:    slot = 2'd1;
         MODE_CIRCULAR:  slot = 2'd1;
         MODE_STOKES:    slot = 2'd3;
         default:        slot = 2'd0;
      endcase
      return slot;
   endfunction

endpackage

/* rtl/ppd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polarization product detector front end
// Accepts sample pairs, forms the eight partial products and the per-mode
// product values, and pushes one entry per transaction into the queue.
// ----------------------------------------------------------------------------
module ppd_front
   import ppd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ppd_req_type          req_data,
   input  logic [MODE_BITS-1:0] mode,
   output logic                 push,
   output ppd_entry_type        push_data,
   input  logic                 queue_full
);

   logic                 s1_valid_ff, s1_valid_in;
   ppd_req_type          s1_data_ff, s1_data_in;
   logic [MODE_BITS-1:0] s1_mode_ff, s1_mode_in;

   logic                         s2_valid_ff, s2_valid_in;
   logic [MODE_BITS-1:0]         s2_mode_ff, s2_mode_in;
   logic signed [VALUE_BITS-1:0] prod_ff [NUM_PRODS];
   logic signed [VALUE_BITS-1:0] prod_in [NUM_PRODS];

   logic s2_free;
   logic s1_load;

   logic signed [OP_BITS-1:0]   xr, xi, yr, yi;
   logic signed [OP_BITS-1:0]   op_a [NUM_PRODS];
   logic signed [OP_BITS-1:0]   op_b [NUM_PRODS];
   logic signed [PROD_BITS-1:0] prod_full [NUM_PRODS];

   logic signed [VALUE_BITS-1:0] sum_x, sum_y;

   assign push      = s2_valid_ff && !queue_full;
   assign s2_free   = !s2_valid_ff || !queue_full;
   assign s1_load   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_load;

   // Stage 1: input register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      s1_mode_in  = s1_mode_ff;
      if (s1_load) begin
         s1_valid_in = req_valid;
         s1_data_in  = req_data;
         s1_mode_in  = mode;
      end
   end

   // Operand selection: the circular mode squares the combined polarizations.
   always_comb begin
      xr = OP_BITS'(s1_data_ff.x_re);
      xi = OP_BITS'(s1_data_ff.x_im);
      yr = OP_BITS'(s1_data_ff.y_re);
      yi = OP_BITS'(s1_data_ff.y_im);
      if (s1_mode_ff == MODE_CIRCULAR) begin
         op_a[0] = xr - yi;
         op_a[1] = xi + yr;
         op_a[2] = xr + yi;
         op_a[3] = xi - yr;
      end else begin
         op_a[0] = xr;
         op_a[1] = xi;
         op_a[2] = yr;
         op_a[3] = yi;
      end
      op_b[0] = op_a[0];
      op_b[1] = op_a[1];
      op_b[2] = op_a[2];
      op_b[3] = op_a[3];
      op_a[4] = xr;  op_b[4] = yr;
      op_a[5] = xi;  op_b[5] = yi;
      op_a[6] = xi;  op_b[6] = yr;
      op_a[7] = xr;  op_b[7] = yi;
      for (int i = 0; i < NUM_PRODS; i++) begin
         prod_full[i] = op_a[i] * op_b[i];
      end
   end

   // Stage 2: product register, wrapped or extended to the result width.
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_mode_in  = s2_mode_ff;
      for (int i = 0; i < NUM_PRODS; i++) begin
         prod_in[i] = prod_ff[i];
      end
      if (s2_free) begin
         s2_valid_in = s1_valid_ff;
         s2_mode_in  = s1_mode_ff;
         for (int i = 0; i < NUM_PRODS; i++) begin
            prod_in[i] = VALUE_BITS'(prod_full[i]);
         end
      end
   end

   // Per-mode product values, all modulo two to the result width.
   always_comb begin
      sum_x = prod_ff[0] + prod_ff[1];
      sum_y = prod_ff[2] + prod_ff[3];
      push_data.mode     = s2_mode_ff;
      push_data.value[2] = (prod_ff[4] + prod_ff[5]) <<< 2;
      push_data.value[3] = (prod_ff[7] - prod_ff[6]) <<< 2;
      unique case (s2_mode_ff)
         MODE_LINEAR: begin
            push_data.value[0] = sum_x <<< 1;
            push_data.value[1] = sum_y <<< 1;
         end
         MODE_CIRCULAR: begin
            push_data.value[0] = sum_x;
            push_data.value[1] = sum_y;
         end
         default: begin
            push_data.value[0] = (sum_x + sum_y) <<< 1;
            push_data.value[1] = (sum_x - sum_y) <<< 1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_data_ff <= s1_data_in;
      s1_mode_ff <= s1_mode_in;
      s2_mode_ff <= s2_mode_in;
      for (int i = 0; i < NUM_PRODS; i++) begin
         prod_ff[i] <= prod_in[i];
      end
   end

endmodule

/* rtl/ppd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polarization product detector queue
// Small FIFO of computed entries between the front end and the emitter.
// ----------------------------------------------------------------------------
module ppd_queue
   import ppd_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  ppd_entry_type push_data,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output ppd_entry_type head
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   ppd_entry_type       entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] ptr);
      return (ptr == PTR_BITS'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign full       = (count_ff == CNT_BITS'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/ppd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polarization product detector emitter
// Walks queue head products to the output register, one per unstalled cycle.
// ----------------------------------------------------------------------------
module ppd_back
   import ppd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  ppd_entry_type head,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output ppd_rsp_type   rsp_data
);

   logic                 rsp_valid_ff, rsp_valid_in;
   ppd_rsp_type          rsp_data_ff, rsp_data_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;

   logic load;
   logic take;
   logic last;

   assign load = !rsp_valid_ff || !rsp_stall;
   assign take = load && head_valid;
   assign last = (slot_ff == last_slot(head.mode));
   assign pop  = take && last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      slot_in      = slot_ff;
      if (load) begin
         rsp_valid_in = head_valid;
      end
      if (take) begin
         rsp_data_in.product_value = head.value[slot_ff];
         rsp_data_in.product_slot  = slot_ff;
         rsp_data_in.last_of_run   = last;
         slot_in                   = last ? '0 : slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         slot_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* rtl/polarization_product_detector_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polarization product detector
// Dual-polarization power and Stokes product detector with mode register.
// ----------------------------------------------------------------------------
// Each transaction on the req_ channel is one complex X/Y sample pair; the
// rsp_ channel returns its run of products, one per cycle while rsp_stall is
// low: one in intensity mode, two in linear or circular mode, four in Stokes
// mode, with the slot number and a flag on the last product. Sustained rate
// is therefore one pair per cycle in intensity mode and lower in the other
// modes, set by the single result channel. A product passes an input
// register, a multiplier register, and the queue entry feeding the output
// register. The queue lets the front end keep accepting pairs while results
// wait. Write product_mode through csr_ only while the block is idle.
module polarization_product_detector_top
   import ppd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ppd_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ppd_rsp_type          rsp_data,
   input  logic                 csr_wr_en,
   input  logic [MODE_BITS-1:0] csr_wr_data
);

   logic [MODE_BITS-1:0] mode_ff, mode_in;

   logic          push;
   ppd_entry_type push_data;
   logic          queue_full;
   logic          pop;
   logic          head_valid;
   ppd_entry_type head;

   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_INTENSITY;
      end else begin
         mode_ff <= mode_in;
      end
   end

   ppd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .mode       (mode_ff),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   ppd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   ppd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polarization product detector testbench
// Drives X/Y sample pairs through every product mode under random back
// pressure and checks each product against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;
   import ppd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   ppd_req_type          req_data;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   ppd_rsp_type          rsp_data;
   logic                 csr_wr_en;
   logic [MODE_BITS-1:0] csr_wr_data;

   logic [MODE_BITS-1:0] product_mode_copy;
   ppd_rsp_type          expected_products[$];
   ppd_rsp_type          oldest_product;
   int                   sender_idle_pct   = 0;
   int                   receiver_idle_pct = 0;
   int                   failures          = 0;
   int                   pairs_sent        = 0;
   int                   products_checked  = 0;
   int                   pairs_per_mode[4] = '{0, 0, 0, 0};
   int                   cycle_count       = 0;

   polarization_product_detector_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic void queue_product(input logic signed [63:0] value, input int slot,
                                         input bit last);
      ppd_rsp_type product;
      product.product_value = value[VALUE_BITS-1:0];
      product.product_slot  = SLOT_BITS'(slot);
      product.last_of_run   = last;
      expected_products.push_back(product);
   endfunction

   function automatic void predict_products(input ppd_req_type pair,
                                            input logic [MODE_BITS-1:0] mode);
      logic signed [63:0] xr, xi, yr, yi, power_x, power_y;
      logic signed [63:0] sum_re, sum_im, diff_re, diff_im, cross_re, cross_im;
      xr = pair.x_re;
      xi = pair.x_im;
      yr = pair.y_re;
      yi = pair.y_im;
      power_x = xr * xr + xi * xi;
      power_y = yr * yr + yi * yi;
      case (mode)
         MODE_INTENSITY: begin
            queue_product(2 * (power_x + power_y), 0, 1'b1);
         end
         MODE_LINEAR: begin
            queue_product(2 * power_x, 0, 1'b0);
            queue_product(2 * power_y, 1, 1'b1);
         end
         MODE_CIRCULAR: begin
            // X + iY and X - iY, each squared magnitude already carries the halving.
            sum_re  = xr - yi;
            sum_im  = xi + yr;
            diff_re = xr + yi;
            diff_im = xi - yr;
            queue_product(sum_re * sum_re + sum_im * sum_im, 0, 1'b0);
            queue_product(diff_re * diff_re + diff_im * diff_im, 1, 1'b1);
         end
         default: begin
            cross_re = xr * yr + xi * yi;
            cross_im = xi * yr - xr * yi;
            queue_product(2 * (power_x + power_y), 0, 1'b0);
            queue_product(2 * (power_x - power_y), 1, 1'b0);
            queue_product(4 * cross_re, 2, 1'b0);
            queue_product(-4 * cross_im, 3, 1'b1);
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic logic signed [SAMPLE_BITS-1:0] random_component();
      case ($urandom_range(0, 7))
         0:       return SAMPLE_MIN;
         1:       return SAMPLE_MAX;
         2:       return '0;
         3:       return '1;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic ppd_req_type random_pair();
      ppd_req_type pair;
      pair.x_re = random_component();
      pair.x_im = random_component();
      pair.y_re = random_component();
      pair.y_im = random_component();
      return pair;
   endfunction

   function automatic ppd_req_type edge_pair(input int which);
      ppd_req_type pair;
      case (which)
         0:       pair = '{'0, '0, '0, '0};
         1:       pair = '{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN};
         2:       pair = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX};
         3:       pair = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX};
         default: pair = '{SAMPLE_MIN, SAMPLE_MIN, '0, '0};
      endcase
      return pair;
   endfunction

   task automatic send_sample_pair(input ppd_req_type pair);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pair;
      do @(posedge clock); while (req_stall);
      predict_products(pair, product_mode_copy);
      pairs_sent++;
      pairs_per_mode[product_mode_copy]++;
      @(negedge clock);
   endtask

   // The mode may only change once every product of the previous setting is out.
   task automatic write_mode(input logic [MODE_BITS-1:0] mode);
      req_valid <= 1'b0;
      while (expected_products.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      product_mode_copy = mode;
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_reset_default_mode();
      for (int i = 0; i < 3; i++) send_sample_pair(edge_pair(i));
   endtask

   task automatic test_edge_samples_all_modes();
      logic [MODE_BITS-1:0] modes[4] = '{MODE_STOKES, MODE_CIRCULAR, MODE_LINEAR,
                                         MODE_INTENSITY};
      foreach (modes[m]) begin
         write_mode(modes[m]);
         for (int i = 0; i < 5; i++) send_sample_pair(edge_pair(i));
      end
   endtask

   task automatic test_random_mixed_modes(input int sender_pct, input int receiver_pct,
                                          input int count);
      int sent;
      int burst;
      sent = 0;
      sender_idle_pct   = sender_pct;
      receiver_idle_pct = receiver_pct;
      while (sent < count) begin
         write_mode(MODE_BITS'($urandom_range(0, 3)));
         burst = $urandom_range(6, 24);
         for (int n = 0; n < burst && sent < count; n++) begin
            send_sample_pair(random_pair());
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------- checking
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_products.size() == 0) begin
            $error("unexpected product: value %0d slot %0d last %0b",
                   rsp_data.product_value, rsp_data.product_slot, rsp_data.last_of_run);
            failures++;
         end else begin
            oldest_product = expected_products.pop_front();
            products_checked++;
            if (rsp_data.product_value !== oldest_product.product_value) begin
               $error("product_value: expected %0d, got %0d",
                      oldest_product.product_value, rsp_data.product_value);
               failures++;
            end
            if (rsp_data.product_slot !== oldest_product.product_slot) begin
               $error("product_slot: expected %0d, got %0d",
                      oldest_product.product_slot, rsp_data.product_slot);
               failures++;
            end
            if (rsp_data.last_of_run !== oldest_product.last_of_run) begin
               $error("last_of_run: expected %0b, got %0b",
                      oldest_product.last_of_run, rsp_data.last_of_run);
               failures++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("** polarization_product_detector_top: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data          = '0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      product_mode_copy = MODE_INTENSITY;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_default_mode();
      test_edge_samples_all_modes();
      test_random_mixed_modes(37, 62, 115);
      test_random_mixed_modes(62, 37, 115);
      test_random_mixed_modes(0, 0, 115);

      req_valid <= 1'b0;
      while (expected_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d sample pairs: %0d intensity, %0d linear, %0d circular, %0d Stokes.",
               pairs_sent, pairs_per_mode[MODE_INTENSITY], pairs_per_mode[MODE_LINEAR],
               pairs_per_mode[MODE_CIRCULAR], pairs_per_mode[MODE_STOKES]);
      $display("Checked %0d products with %0d mismatches in %0d cycles.",
               products_checked, failures, cycle_count);
      if (failures == 0) begin
         $display("** polarization_product_detector_top: PASSED **");
      end else begin
         $display("** polarization_product_detector_top: FAILED **");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/ppd_pkg.sv
rtl/ppd_front.sv
rtl/ppd_queue.sv
rtl/ppd_back.sv
rtl/polarization_product_detector_top.sv
dv/tb.sv
